@@ src/pkvt_pkg.sv @@
package pkvt_pkg;

	localparam int CAPACITY   = 64;
	localparam int KEY_BITS   = 16;
	localparam int VALUE_BITS = 16;

	// port widths
	localparam int OP_W     = 3;
	localparam int KEY_W    = 16;
	localparam int VALUE_W  = 16;
	localparam int INDEX_W  = 6;
	localparam int STATUS_W = 3;
	localparam int NUM_W    = 7;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int PAIR_W = KEY_BITS + VALUE_BITS;

	localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
	localparam logic [OP_W-1:0] OP_REM_AT  = 3'd1;
	localparam logic [OP_W-1:0] OP_REM_KEY = 3'd2;
	localparam logic [OP_W-1:0] OP_EXISTS  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ    = 3'd4;

	localparam logic [STATUS_W-1:0] STS_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] STS_FULL  = 3'd1;
	localparam logic [STATUS_W-1:0] STS_DUP   = 3'd2;
	localparam logic [STATUS_W-1:0] STS_EMPTY = 3'd3;
	localparam logic [STATUS_W-1:0] STS_INDEX = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

endpackage

@@ src/pkvt_ram.sv @@
module pkvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/paired_key_value_table.sv @@
// a stalled result word holds the table in its finish state until the output slot frees
// throughput: one word at a time, the next accepted the cycle after the result is loaded;
// the scan is set by the single read port walking one entry a cycle
// reset: arst_n clears the entry count and control state; the pair memory is left as is
module paired_key_value_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pkvt_pkg::OP_W-1:0]     op,
	input  logic [pkvt_pkg::KEY_W-1:0]    key,
	input  logic [pkvt_pkg::VALUE_W-1:0]  value,
	input  logic [pkvt_pkg::INDEX_W-1:0]  index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pkvt_pkg::STATUS_W-1:0] status,
	output logic                          found,
	output logic [pkvt_pkg::KEY_W-1:0]    key_out,
	output logic [pkvt_pkg::VALUE_W-1:0]  value_out,
	output logic [pkvt_pkg::NUM_W-1:0]    removed,
	output logic [pkvt_pkg::NUM_W-1:0]    count
);
	import pkvt_pkg::*;

	state_t state_q;

	logic [OP_W-1:0]       op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [STATUS_W-1:0]   sts_q;
	logic                  dup_q;
	logic                  found_q;
	logic [KEY_BITS-1:0]   kout_q;
	logic [VALUE_BITS-1:0] vout_q;
	logic [CNT_W-1:0]      removed_q;
	logic [CNT_W-1:0]      wr_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      end_q;

	logic                  rd_v_s1;
	logic [ADDR_W-1:0]     rd_addr_s1;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  found_out_q;
	logic [KEY_W-1:0]      key_out_q;
	logic [VALUE_W-1:0]    value_out_q;
	logic [NUM_W-1:0]      removed_out_q;
	logic [NUM_W-1:0]      count_out_q;

	logic                  issue;
	logic                  out_free;
	logic                  accept;
	logic                  we;
	logic [ADDR_W-1:0]     waddr;
	logic [PAIR_W-1:0]     wdata;
	logic [PAIR_W-1:0]     rdata;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_value;
	logic                  key_hit;
	logic                  append_ok;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign issue     = (state_q == ST_SCAN) && (rd_ptr_q < end_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign rd_key    = rdata[PAIR_W-1:VALUE_BITS];
	assign rd_value  = rdata[VALUE_BITS-1:0];
	assign key_hit   = rd_v_s1 && (rd_key == key_q);
	assign append_ok = (op_q == OP_APPEND) && (sts_q == STS_OK) && !dup_q;

	// write port: compaction during the scan, the appended pair at the end
	always_comb begin
		we    = 1'b0;
		waddr = rd_addr_s1 - ADDR_W'(1);
		wdata = rdata;
		if (state_q == ST_FINISH) begin
			we    = out_free && append_ok;
			waddr = count_q[ADDR_W-1:0];
			wdata = {key_q, value_q};
		end else if (rd_v_s1 && op_q == OP_REM_AT) begin
			we = 1'b1;
		end else if (rd_v_s1 && op_q == OP_REM_KEY && !key_hit) begin
			we    = 1'b1;
			waddr = wr_ptr_q[ADDR_W-1:0];
		end
	end

	pkvt_ram #(
		.WIDTH (PAIR_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_ptr_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1     <= issue;
			out_valid_q <= (state_q == ST_FINISH && out_free) || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!issue && !rd_v_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (append_ok) begin
							count_q <= count_q + CNT_W'(1);
						end else if (op_q == OP_REM_AT && sts_q == STS_OK) begin
							count_q <= count_q - CNT_W'(1);
						end else if (op_q == OP_REM_KEY) begin
							count_q <= wr_ptr_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operation registers, scan bounds and result accumulation
	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_ptr_q[ADDR_W-1:0];
		if (issue) begin
			rd_ptr_q <= rd_ptr_q + CNT_W'(1);
		end
		if (accept) begin
			op_q      <= op;
			key_q     <= KEY_BITS'(key);
			value_q   <= VALUE_BITS'(value);
			dup_q     <= 1'b0;
			found_q   <= 1'b0;
			kout_q    <= '0;
			vout_q    <= '0;
			wr_ptr_q  <= '0;
			unique case (op)
				OP_APPEND: begin
					rd_ptr_q  <= '0;
					removed_q <= '0;
					if (int'(count_q) >= CAPACITY) begin
						sts_q <= STS_FULL;
						end_q <= '0;
					end else begin
						sts_q <= STS_OK;
						end_q <= count_q;
					end
				end
				OP_REM_AT: begin
					if (count_q == '0) begin
						sts_q     <= STS_EMPTY;
						rd_ptr_q  <= '0;
						end_q     <= '0;
						removed_q <= '0;
					end else if (int'(index) >= int'(count_q)) begin
						sts_q     <= STS_INDEX;
						rd_ptr_q  <= '0;
						end_q     <= '0;
						removed_q <= '0;
					end else begin
						sts_q     <= STS_OK;
						rd_ptr_q  <= CNT_W'(index) + CNT_W'(1);
						end_q     <= count_q;
						removed_q <= CNT_W'(1);
					end
				end
				OP_REM_KEY, OP_EXISTS: begin
					sts_q     <= STS_OK;
					rd_ptr_q  <= '0;
					end_q     <= count_q;
					removed_q <= '0;
				end
				OP_READ: begin
					removed_q <= '0;
					if (int'(index) >= int'(count_q)) begin
						sts_q    <= STS_INDEX;
						rd_ptr_q <= '0;
						end_q    <= '0;
					end else begin
						sts_q    <= STS_OK;
						rd_ptr_q <= CNT_W'(index);
						end_q    <= CNT_W'(index) + CNT_W'(1);
					end
				end
				default: begin
					sts_q     <= STS_OK;
					rd_ptr_q  <= '0;
					end_q     <= '0;
					removed_q <= '0;
				end
			endcase
		end
		if (rd_v_s1) begin
			unique case (op_q)
				OP_APPEND: begin
					if (key_hit && rd_value == value_q) begin
						dup_q <= 1'b1;
					end
				end
				OP_REM_KEY: begin
					if (key_hit) begin
						removed_q <= removed_q + CNT_W'(1);
					end else begin
						wr_ptr_q <= wr_ptr_q + CNT_W'(1);
					end
				end
				OP_EXISTS: begin
					if (key_hit) begin
						found_q <= 1'b1;
					end
				end
				OP_READ: begin
					kout_q <= rd_key;
					vout_q <= rd_value;
				end
				default: begin
				end
			endcase
		end
	end

	// output word, loaded only when the slot is free so a stalled word holds
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			status_q      <= dup_q ? STS_DUP : sts_q;
			found_out_q   <= found_q;
			key_out_q     <= KEY_W'(kout_q);
			value_out_q   <= VALUE_W'(vout_q);
			removed_out_q <= NUM_W'(removed_q);
			if (append_ok) begin
				count_out_q <= NUM_W'(count_q + CNT_W'(1));
			end else if (op_q == OP_REM_AT && sts_q == STS_OK) begin
				count_out_q <= NUM_W'(count_q - CNT_W'(1));
			end else if (op_q == OP_REM_KEY) begin
				count_out_q <= NUM_W'(wr_ptr_q);
			end else begin
				count_out_q <= NUM_W'(count_q);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign found     = found_out_q;
	assign key_out   = key_out_q;
	assign value_out = value_out_q;
	assign removed   = removed_out_q;
	assign count     = count_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= CAPACITY)
		else $error("entry count beyond capacity");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> state_q == ST_SCAN)
		else $error("read data returned outside the scan");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result word raised outside finish");

	a_count_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(state_q == ST_FINISH) && $past(out_free))
		else $error("entry count changed outside finish");

endmodule
